@@ sv/uec_pkg.sv @@
// ----------------------------------------------------------------------------
// URL escape codec package
// Shared types, character constants and small helper functions.
// ----------------------------------------------------------------------------
package uec_pkg;

	localparam logic [1:0] MODE_FORM     = 2'd0;
	localparam logic [1:0] MODE_ALL      = 2'd1;
	localparam logic [1:0] MODE_SELECT   = 2'd2;
	localparam logic [1:0] MODE_DECODE   = 2'd3;

	localparam logic [1:0] REG_MODE      = 2'd0;
	localparam logic [1:0] REG_ESC_CHAR  = 2'd1;
	localparam logic [1:0] REG_ESC_AMP   = 2'd2;

	localparam logic [7:0] CH_PERCENT    = 8'h25;
	localparam logic [7:0] CH_HASH       = 8'h23;
	localparam logic [7:0] CH_PLUS       = 8'h2B;
	localparam logic [7:0] CH_SPACE      = 8'h20;
	localparam logic [7:0] CH_SLASH      = 8'h2F;
	localparam logic [7:0] CH_EQUAL      = 8'h3D;
	localparam logic [7:0] CH_AMP        = 8'h26;
	localparam logic [7:0] CH_CR         = 8'h0D;
	localparam logic [7:0] CH_LF         = 8'h0A;
	localparam logic [7:0] CH_ZERO       = 8'h30;
	localparam logic [7:0] CH_NINE       = 8'h39;
	localparam logic [7:0] CH_UP_A       = 8'h41;
	localparam logic [7:0] CH_UP_Z       = 8'h5A;
	localparam logic [7:0] CH_LO_A       = 8'h61;
	localparam logic [7:0] CH_LO_Z       = 8'h7A;
	// 'A' - 10: maps an upper-case letter digit to its value.
	localparam logic [7:0] ALPHA_OFS     = 8'd55;
	localparam logic [3:0] NIB_MASK      = 4'hF;

	localparam logic [1:0] GRP_WORDS     = 2'd3;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_DIGIT1 = 2'd1,
		PH_DIGIT2 = 2'd2
	} uec_phase_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] esc_char;
		logic       esc_amp;
	} uec_cfg_t;

	typedef struct packed {
		uec_phase_t phase;
		logic [3:0] nib;
	} uec_dec_t;

	// One group of result words produced by a single input word.
	typedef struct packed {
		logic [1:0]      cnt;
		logic [2:0][7:0] bytes;
		logic            last;
		logic            trunc;
	} uec_grp_t;

	function automatic logic [7:0] hex_digit(input logic [3:0] nib);
		logic [7:0] v;
		v = {4'h0, nib & NIB_MASK};
		if (nib > 4'd9) begin
			return v + ALPHA_OFS;
		end
		return v + CH_ZERO;
	endfunction

	function automatic logic [7:0] digit_value(input logic [7:0] c);
		if (c > CH_NINE) begin
			return c - ALPHA_OFS;
		end
		return c - CH_ZERO;
	endfunction

	function automatic logic is_alnum(input logic [7:0] c);
		return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z) ||
			(c >= CH_ZERO && c <= CH_NINE);
	endfunction

endpackage

@@ sv/url_escape_codec_top.sv @@
// An accepted word passes the input register and the result buffer before it shows.
// Throughput: one input word per cycle while each yields one result word and m_tready
// is high; an escaped byte gives three result words, sent one per cycle when ready.
// Decode words that only open or continue an escape leave no result and never wait.
// Reset clears the pipeline, the decoder state and loads the register defaults.
// ----------------------------------------------------------------------------
// URL escape codec top level
// Input register, translator, and a three-word result buffer feeding the
// output stream; APB registers for mode, escape character and ampersand escape.
// ----------------------------------------------------------------------------
module url_escape_codec_top (
	input  logic       clk,
	input  logic       arst_n,
	// APB configuration port
	input  logic       psel,
	input  logic       penable,
	input  logic       pwrite,
	input  logic [3:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic       pready,
	// Input stream
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	input  logic       s_tlast,
	// Output stream
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic       m_tlast,
	output logic       m_tuser    // [0] truncated
);

	uec_pkg::uec_cfg_t cfg_q;
	uec_pkg::uec_dec_t dec_q;
	uec_pkg::uec_dec_t dec_nxt;
	uec_pkg::uec_grp_t grp;

	logic       s1_valid;
	logic [7:0] s1_byte;
	logic       s1_last;
	logic       s1_go;

	logic            buf_valid_q;
	logic [1:0]      buf_cnt_q;
	logic [1:0]      buf_idx_q;
	logic [2:0][7:0] buf_byte_q;
	logic            buf_last_q;
	logic            buf_trunc_q;
	logic            buf_end;
	logic            buf_done;
	logic            buf_free;
	logic            wr_en;

	// Configuration registers
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode     <= uec_pkg::MODE_FORM;
			cfg_q.esc_char <= uec_pkg::CH_PERCENT;
			cfg_q.esc_amp  <= 1'b1;
		end else if (wr_en) begin
			case (paddr[3:2])
				uec_pkg::REG_MODE:     cfg_q.mode     <= pwdata[1:0];
				uec_pkg::REG_ESC_CHAR: cfg_q.esc_char <= pwdata[7:0];
				uec_pkg::REG_ESC_AMP:  cfg_q.esc_amp  <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			uec_pkg::REG_MODE:     prdata = {30'd0, cfg_q.mode};
			uec_pkg::REG_ESC_CHAR: prdata = {24'd0, cfg_q.esc_char};
			uec_pkg::REG_ESC_AMP:  prdata = {31'd0, cfg_q.esc_amp};
			default:               prdata = '0;
		endcase
	end

	// Result buffer handshake
	assign buf_end  = buf_idx_q == (buf_cnt_q - 2'd1);
	assign buf_done = m_tvalid && m_tready && buf_end;
	assign buf_free = !buf_valid_q || buf_done;

	// A word with no result only updates the decoder state.
	assign s1_go    = s1_valid && (grp.cnt == 2'd0 || buf_free);
	assign s_tready = !s1_valid || s1_go;

	uec_xlate u_xlate (
		.cfg     (cfg_q),
		.st      (dec_q),
		.in_byte (s1_byte),
		.in_last (s1_last),
		.grp     (grp),
		.nxt     (dec_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid    <= 1'b0;
			dec_q.phase <= uec_pkg::PH_IDLE;
			dec_q.nib   <= '0;
			buf_valid_q <= 1'b0;
			buf_cnt_q   <= '0;
			buf_idx_q   <= '0;
		end else begin
			if (s_tready) begin
				s1_valid <= s_tvalid;
			end
			if (s1_go) begin
				dec_q <= dec_nxt;
			end
			if (s1_go && grp.cnt != 2'd0) begin
				buf_valid_q <= 1'b1;
				buf_cnt_q   <= grp.cnt;
				buf_idx_q   <= '0;
			end else if (buf_done) begin
				buf_valid_q <= 1'b0;
			end else if (m_tvalid && m_tready) begin
				buf_idx_q <= buf_idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			s1_byte <= s_tdata;
			s1_last <= s_tlast;
		end
		if (s1_go && grp.cnt != 2'd0) begin
			buf_byte_q  <= grp.bytes;
			buf_last_q  <= grp.last;
			buf_trunc_q <= grp.trunc;
		end
	end

	assign m_tvalid = buf_valid_q;
	assign m_tdata  = buf_byte_q[buf_idx_q];
	assign m_tlast  = buf_last_q && buf_end;
	assign m_tuser  = buf_trunc_q;

`ifndef NO_ASSERTIONS
	a_cnt_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		buf_valid_q |-> (buf_cnt_q != 2'd0 && buf_idx_q < buf_cnt_q))
		else $error("result buffer holds a bad word count or index");

	a_trunc_form: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tlast && m_tdata == 8'd0 && buf_cnt_q == 2'd1))
		else $error("truncation report is not a single zero last word");

	a_encode_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && cfg_q.mode != uec_pkg::MODE_DECODE) |=>
		(dec_q.phase == uec_pkg::PH_IDLE && dec_q.nib == 4'd0))
		else $error("encode word left the decoder inside an escape");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(buf_valid_q && !buf_done) |-> !(s1_go && grp.cnt != 2'd0))
		else $error("result group loaded over an unfinished group");
`endif

endmodule

@@ sv/uec_xlate.sv @@
// ----------------------------------------------------------------------------
// URL escape translator
// Maps one input word and the decoder state to a group of up to three
// result words and the next decoder state.
// ----------------------------------------------------------------------------
module uec_xlate (
	input  uec_pkg::uec_cfg_t cfg,
	input  uec_pkg::uec_dec_t st,
	input  logic [7:0]        in_byte,
	input  logic              in_last,
	output uec_pkg::uec_grp_t grp,
	output uec_pkg::uec_dec_t nxt
);

	logic [7:0] dval;
	logic       esc;

	assign dval = uec_pkg::digit_value(in_byte);

	always_comb begin
		grp       = '0;
		nxt.phase = uec_pkg::PH_IDLE;
		nxt.nib   = '0;
		esc       = 1'b0;
		if (cfg.mode == uec_pkg::MODE_DECODE) begin
			case (st.phase)
				uec_pkg::PH_DIGIT1: begin
					if (in_last) begin
						grp.cnt   = 2'd1;
						grp.last  = 1'b1;
						grp.trunc = 1'b1;
					end else begin
						nxt.phase = uec_pkg::PH_DIGIT2;
						nxt.nib   = dval[3:0];
					end
				end
				uec_pkg::PH_DIGIT2: begin
					grp.cnt      = 2'd1;
					grp.bytes[0] = {st.nib, 4'h0} + dval;
					grp.last     = in_last;
				end
				default: begin
					// The plus test comes first, so a plus never opens an escape.
					if (in_byte == uec_pkg::CH_PLUS) begin
						grp.cnt      = 2'd1;
						grp.bytes[0] = uec_pkg::CH_SPACE;
						grp.last     = in_last;
					end else if (in_byte == cfg.esc_char) begin
						if (in_last) begin
							grp.cnt   = 2'd1;
							grp.last  = 1'b1;
							grp.trunc = 1'b1;
						end else begin
							nxt.phase = uec_pkg::PH_DIGIT1;
						end
					end else begin
						grp.cnt      = 2'd1;
						grp.bytes[0] = in_byte;
						grp.last     = in_last;
					end
				end
			endcase
		end else begin
			case (cfg.mode)
				uec_pkg::MODE_ALL: begin
					esc = 1'b1;
				end
				uec_pkg::MODE_FORM: begin
					esc = !(in_byte == uec_pkg::CH_SPACE || uec_pkg::is_alnum(in_byte));
				end
				default: begin
					esc = in_byte == uec_pkg::CH_SLASH || in_byte == uec_pkg::CH_EQUAL ||
						in_byte == uec_pkg::CH_CR || in_byte == uec_pkg::CH_LF ||
						in_byte == uec_pkg::CH_PLUS ||
						(in_byte == uec_pkg::CH_AMP && cfg.esc_amp);
				end
			endcase
			grp.last = in_last;
			if (esc) begin
				grp.cnt      = uec_pkg::GRP_WORDS;
				grp.bytes[0] = cfg.esc_char;
				grp.bytes[1] = uec_pkg::hex_digit(in_byte[7:4]);
				grp.bytes[2] = uec_pkg::hex_digit(in_byte[3:0]);
			end else begin
				grp.cnt      = 2'd1;
				grp.bytes[0] = (in_byte == uec_pkg::CH_SPACE) ? uec_pkg::CH_PLUS : in_byte;
			end
		end
	end

endmodule
